[rtl/core/chc_pkg.sv]
`default_nettype none

package chc_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    // Datapath widths: 16-bit samples scaled by 256, plus CORDIC growth and negation headroom
    localparam int XY_W        = 27;
    localparam int Z_W         = 27;
    localparam int ZQ_BITS     = 16;
    localparam int PRESCALE_SH = 8;

    localparam logic signed [Z_W-1:0] DEG180_Q = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] DEG360_Q = Z_W'(360 * 65536);

    localparam int ATAN_TABLE_LEN = 24;

    // atan(2^-i) in Q16 degrees, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_Q16 [ATAN_TABLE_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    // floor(v / 360) = (v * REF_RECIP) >> REF_RECIP_SH, exact for any 15-bit v
    localparam logic [15:0] REF_RECIP    = 16'd46604;
    localparam int          REF_RECIP_SH = 24;

    localparam logic [1:0] QUAD_FRONT = 2'd0;
    localparam logic [1:0] QUAD_RIGHT = 2'd1;
    localparam logic [1:0] QUAD_BACK  = 2'd2;
    localparam logic [1:0] QUAD_LEFT  = 2'd3;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } chc_vec_t;

endpackage

`default_nettype wire

[rtl/core/compass_heading_classifier.sv]
`default_nettype none

// Compass heading classifier. Each beat on s_ carries one X/Y magnetometer sample; each beat on
// m_ returns its heading atan2(y, x) in 2^-ANGLE_FRAC_BITS degree units (0 to below 360), the
// compass octant (0 North .. 7 North-West) and the direction relative to the reference heading
// (0 front, 1 right, 2 back, 3 left). A zero vector reads as heading 0. One sample is taken per
// cycle while s_tready is high. The path is an input register, one register per CORDIC
// rotation, then four stages for wrap and rounding, range fold, octant and offset, quadrant.
// The pipeline fills bubbles under back-pressure and drops no beat. A reference heading written
// on cfg_wr_en is reduced modulo 360 degrees through ref_reg, ref_prod_reg and ref_red_reg and
// applies to every sample accepted after the write.
module compass_heading_classifier
    import chc_pkg::*;
#(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,   // reference_heading
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [15:0] mag_x, [31:16] mag_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata        // [14:0] heading_angle, [17:15] compass_octant,
                                            // [19:18] relative_quadrant, [23:20] zero
);

    localparam int H_W      = 9 + ANGLE_FRAC_BITS;
    localparam int ROUND_SH = ZQ_BITS - ANGLE_FRAC_BITS;
    localparam logic [H_W-1:0] FULL    = H_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [H_W-1:0] DEG45   = H_W'(45 << ANGLE_FRAC_BITS);
    localparam logic [H_W-1:0] DEG135  = H_W'(135 << ANGLE_FRAC_BITS);
    localparam logic [H_W-1:0] DEG225  = H_W'(225 << ANGLE_FRAC_BITS);
    localparam logic [H_W-1:0] DEG315  = H_W'(315 << ANGLE_FRAC_BITS);
    localparam logic [Z_W-1:0] HALF_LSB = Z_W'(1 << (ROUND_SH - 1));

    // ---------------- reference heading ----------------
    logic [14:0]    ref_reg;
    logic [30:0]    ref_prod_reg;
    logic [H_W-1:0] ref_red_reg;
    logic [14:0]    ref_hi;
    logic [14:0]    ref_lo;
    logic [6:0]     ref_quot;
    logic [14:0]    ref_rem;
    logic [H_W-1:0] ref_red_next;

    assign ref_hi       = ref_reg >> ANGLE_FRAC_BITS;
    assign ref_lo       = ref_reg & 15'((1 << ANGLE_FRAC_BITS) - 1);
    assign ref_quot     = ref_prod_reg[REF_RECIP_SH +: 7];
    assign ref_rem      = ref_hi - 15'(ref_quot * 9'd360);
    assign ref_red_next = H_W'((32'(ref_rem) << ANGLE_FRAC_BITS) | 32'(ref_lo));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg      <= '0;
            ref_prod_reg <= '0;
            ref_red_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                ref_reg <= cfg_wr_data;
            end
            ref_prod_reg <= ref_hi * REF_RECIP;
            ref_red_reg  <= ref_red_next;
        end
    end

    // ---------------- stall chain ----------------
    logic       cd_vld [0:CORDIC_STAGES];
    chc_vec_t   cd_vec [0:CORDIC_STAGES];
    logic       cd_en  [0:CORDIC_STAGES];
    logic       a_vld_reg;
    logic       b_vld_reg;
    logic       c_vld_reg;
    logic       d_vld_reg;
    logic       a_en;
    logic       b_en;
    logic       c_en;
    logic       d_en;

    assign d_en = !d_vld_reg || m_tready;
    assign c_en = !c_vld_reg || d_en;
    assign b_en = !b_vld_reg || c_en;
    assign a_en = !a_vld_reg || b_en;

    assign cd_en[CORDIC_STAGES] = !cd_vld[CORDIC_STAGES] || a_en;
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_en
        assign cd_en[k] = !cd_vld[k] || cd_en[k+1];
    end

    assign s_tready = cd_en[0];

    // ---------------- input register ----------------
    logic                   s0_vld_reg;
    chc_vec_t               s0_vec_reg;
    chc_vec_t               s0_vec_next;
    logic signed [XY_W-1:0] in_x;
    logic signed [XY_W-1:0] in_y;

    assign in_x = XY_W'($signed(s_tdata[15:0])) <<< PRESCALE_SH;
    assign in_y = XY_W'($signed(s_tdata[31:16])) <<< PRESCALE_SH;

    // fold the left half plane onto the right and start at 180 degrees
    always_comb begin
        s0_vec_next.zero = (s_tdata[15:0] == 16'd0) && (s_tdata[31:16] == 16'd0);
        if (in_x[XY_W-1]) begin
            s0_vec_next.x = -in_x;
            s0_vec_next.y = -in_y;
            s0_vec_next.z = DEG180_Q;
        end else begin
            s0_vec_next.x = in_x;
            s0_vec_next.y = in_y;
            s0_vec_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (cd_en[0]) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cd_en[0]) begin
            s0_vec_reg <= s0_vec_next;
        end
    end

    assign cd_vld[0] = s0_vld_reg;
    assign cd_vec[0] = s0_vec_reg;

    // ---------------- CORDIC rotations ----------------
    for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
        chc_cordic_stage #(
            .STAGE_IDX (k - 1)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (cd_en[k]),
            .in_valid  (cd_vld[k-1]),
            .in_vec    (cd_vec[k-1]),
            .out_valid (cd_vld[k]),
            .out_vec   (cd_vec[k])
        );
    end

    // ---------------- stage A: wrap and round ----------------
    logic [H_W:0]   a_hr_reg;
    logic           a_zero_reg;
    logic [Z_W-1:0] z_wrap;
    logic [Z_W-1:0] z_round;

    assign z_wrap  = cd_vec[CORDIC_STAGES].z[Z_W-1] ?
                     Z_W'(cd_vec[CORDIC_STAGES].z + DEG360_Q) :
                     Z_W'(cd_vec[CORDIC_STAGES].z);
    assign z_round = z_wrap + HALF_LSB;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_en) begin
            a_vld_reg <= cd_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_hr_reg   <= z_round[ROUND_SH +: H_W+1];
            a_zero_reg <= cd_vec[CORDIC_STAGES].zero;
        end
    end

    // ---------------- stage B: fold 360 to 0, zero vector ----------------
    logic [H_W-1:0] b_h_reg;
    logic [H_W-1:0] b_h_next;

    always_comb begin
        if (a_zero_reg) begin
            b_h_next = '0;
        end else if (a_hr_reg >= (H_W+1)'(FULL)) begin
            b_h_next = H_W'(a_hr_reg - (H_W+1)'(FULL));
        end else begin
            b_h_next = H_W'(a_hr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_h_reg <= b_h_next;
        end
    end

    // ---------------- stage C: octant and offset from reference ----------------
    logic [H_W-1:0] c_h_reg;
    logic [H_W-1:0] c_d_reg;
    logic [2:0]     c_oct_reg;
    logic [3:0]     oct_cnt;
    logic [H_W-1:0] d_next;

    // octant = floor((2h + 45) / 90) mod 8: count the edges at 22.5 + 45k degrees
    always_comb begin
        oct_cnt = '0;
        for (int k = 1; k <= 8; k++) begin
            if ({b_h_reg, 1'b0} >= (H_W+1)'((90 * k - 45) << ANGLE_FRAC_BITS)) begin
                oct_cnt = oct_cnt + 4'd1;
            end
        end
    end

    assign d_next = (b_h_reg >= ref_red_reg) ? H_W'(b_h_reg - ref_red_reg) :
                                               H_W'(b_h_reg + FULL - ref_red_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (c_en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_h_reg   <= b_h_reg;
            c_d_reg   <= d_next;
            c_oct_reg <= oct_cnt[2:0];
        end
    end

    // ---------------- stage D: relative quadrant, output register ----------------
    logic [H_W-1:0] d_h_reg;
    logic [2:0]     d_oct_reg;
    logic [1:0]     d_quad_reg;
    logic [1:0]     quad_next;

    always_comb begin
        if (c_d_reg <= DEG45 || c_d_reg > DEG315) begin
            quad_next = QUAD_FRONT;
        end else if (c_d_reg <= DEG135) begin
            quad_next = QUAD_RIGHT;
        end else if (c_d_reg <= DEG225) begin
            quad_next = QUAD_BACK;
        end else begin
            quad_next = QUAD_LEFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (d_en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_en) begin
            d_h_reg    <= c_h_reg;
            d_oct_reg  <= c_oct_reg;
            d_quad_reg <= quad_next;
        end
    end

    assign m_tvalid = d_vld_reg;
    assign m_tdata  = {4'b0000, d_quad_reg, d_oct_reg, 15'(d_h_reg)};

    // ---------------- assertions ----------------
    // input side stalls only when the pipeline is full up to a waiting output beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s0_vld_reg && d_vld_reg && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (d_h_reg < FULL))
        else $error("heading out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg |-> (c_d_reg < FULL))
        else $error("reference offset out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en ##1 !cfg_wr_en |=> (ref_red_reg < FULL))
        else $error("reduced reference out of range");

endmodule

`default_nettype wire

[rtl/core/chc_cordic_stage.sv]
`default_nettype none

module chc_cordic_stage
    import chc_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire chc_vec_t in_vec,
    output logic          out_valid,
    output chc_vec_t      out_vec
);

    logic                   vld_reg;
    chc_vec_t               vec_reg;
    chc_vec_t               vec_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = in_vec.x >>> STAGE_IDX;
    assign ys = in_vec.y >>> STAGE_IDX;

    // rotate toward the positive x axis
    always_comb begin
        vec_next      = in_vec;
        if (!in_vec.y[XY_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ATAN_Q16[STAGE_IDX];
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ATAN_Q16[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

[tb/tb_compass_heading_classifier.sv]
module tb_compass_heading_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import chc_pkg::*;

    localparam int STAGES         = 16;
    localparam int FRAC           = 6;
    localparam int LATENCY        = STAGES + 5;
    localparam int ITEMS_PER_SET  = 275;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam longint FULL_TURN = longint'(360) << FRAC;
    localparam longint DEG45     = longint'(45) << FRAC;
    localparam longint DEG90     = longint'(90) << FRAC;
    localparam longint DEG135    = longint'(135) << FRAC;
    localparam longint DEG225    = longint'(225) << FRAC;
    localparam longint DEG315    = longint'(315) << FRAC;

    // atan(2^-i) in Q16 degrees
    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Reference settings per random set; index 3 is drawn at run time
    localparam logic [14:0] SET_REFS [6] = '{
        15'd23039, 15'd32767, 15'd0, 15'd0, 15'd23040, 15'd11520
    };

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } mag_sample_t;

    typedef struct packed {
        logic [14:0] heading;
        logic [2:0]  octant;
        logic [1:0]  quadrant;
    } heading_res_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;      // [15:0] mag_x, [31:16] mag_y
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;               // [14:0] heading_angle, [17:15] compass_octant,
                                        // [19:18] relative_quadrant, [23:20] zero

    mag_sample_t  pending_samples[$];
    heading_res_t expected_headings[$];

    logic [14:0] heading_ref = '0;
    bit          no_idle     = 1'b0;
    int          idle_odds   = 4;
    int          src_gap     = 0;
    int          sink_gap    = 0;
    int          stall_cycles = 0;
    int          errors      = 0;

    compass_heading_classifier #(
        .CORDIC_STAGES  (STAGES),
        .ANGLE_FRAC_BITS(FRAC)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic heading_res_t predict_heading(logic signed [15:0] mx,
                                                     logic signed [15:0] my,
                                                     logic [14:0] ref_raw);
        longint x, y, z, xs, ys, h, ref_deg, d;
        heading_res_t r;
        if (mx == 0 && my == 0) begin
            h = 0;
        end else begin
            x = longint'(mx) * 256;
            y = longint'(my) * 256;
            z = 0;
            // fold the left half plane onto the right one
            if (x < 0) begin
                x = -x;
                y = -y;
                z = longint'(180) * 65536;
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_Q16[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_Q16[i];
                end
            end
            if (z < 0)
                z = z + longint'(360) * 65536;
            h = (z + (longint'(1) << (16 - FRAC - 1))) >>> (16 - FRAC);
            if (h >= FULL_TURN)
                h = h - FULL_TURN;
        end
        ref_deg = longint'(ref_raw) % FULL_TURN;
        d = (h + FULL_TURN - ref_deg) % FULL_TURN;
        r.heading = 15'(h);
        r.octant  = 3'(((2 * h + DEG45) / DEG90) & 7);
        if (d <= DEG45 || d > DEG315)
            r.quadrant = QUAD_FRONT;
        else if (d <= DEG135)
            r.quadrant = QUAD_RIGHT;
        else if (d <= DEG225)
            r.quadrant = QUAD_BACK;
        else
            r.quadrant = QUAD_LEFT;
        return r;
    endfunction

    task automatic push_sample(input logic signed [15:0] x, input logic signed [15:0] y);
        mag_sample_t smp;
        smp.x = x;
        smp.y = y;
        pending_samples.push_back(smp);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || expected_headings.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Source: predict on every accepted beat, then load the next one or idle
    always @(posedge aclk) begin : drv
        mag_sample_t smp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_headings.push_back(
                    predict_heading(s_tdata[15:0], s_tdata[31:16], heading_ref));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    smp = pending_samples.pop_front();
                    s_tdata  <= {smp.y, smp.x};
                    s_tvalid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 15) < idle_odds)
                        src_gap = $urandom_range(1, 15);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: back-pressure in random bursts
    always @(posedge aclk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 15) < idle_odds)
                sink_gap = $urandom_range(1, 15);
        end
    end

    always @(posedge aclk) begin : mon
        heading_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_headings.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_headings.pop_front();
                if (m_tdata[14:0] !== want.heading) begin
                    $display("%0t: heading_angle expected %0d actual %0d",
                             $time, want.heading, m_tdata[14:0]);
                    errors++;
                end
                if (m_tdata[17:15] !== want.octant) begin
                    $display("%0t: compass_octant expected %0d actual %0d",
                             $time, want.octant, m_tdata[17:15]);
                    errors++;
                end
                if (m_tdata[19:18] !== want.quadrant) begin
                    $display("%0t: relative_quadrant expected %0d actual %0d",
                             $time, want.quadrant, m_tdata[19:18]);
                    errors++;
                end
            end
        end
    end

    // Count only cycles where work is outstanding and no beat moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_samples.size() == 0 && !s_tvalid && expected_headings.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, expected_headings.size());
                $display("** compass_heading_classifier: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stim
        logic signed [15:0] rx, ry;
        logic signed [15:0] corner_vals [5];
        logic [14:0]        next_ref;
        int                 mode;
        corner_vals = '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed set under the reset reference
        push_sample(0, 0);
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(0, 32767);
        push_sample(0, -32768);
        push_sample(32767, 32767);
        push_sample(-32768, 32767);
        push_sample(-32768, -32768);
        push_sample(32767, -32768);
        push_sample(1, 0);
        push_sample(0, 1);
        push_sample(-1, 0);
        push_sample(0, -1);
        push_sample(-1, -1);
        push_sample(1, -1);
        push_sample(1000, 414);
        push_sample(1000, 415);
        push_sample(1000, -414);
        push_sample(1000, -415);
        push_sample(-1000, 414);
        push_sample(1000, 1000);
        push_sample(-1000, -1000);
        push_sample(3, -1);
        push_sample(-2, -1);
        push_sample(16'sh5555, 16'shAAAA);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            next_ref = (p == 3) ? 15'($urandom) : SET_REFS[p];
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= next_ref;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            heading_ref = next_ref;
            // hold off while the reference is folded mod 360
            repeat (4) @(posedge aclk);
            no_idle   = (p == 5);
            idle_odds = $urandom_range(1, 6);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                mode = $urandom_range(0, 9);
                rx = 16'($urandom);
                ry = 16'($urandom);
                case (mode)
                    4: begin
                        rx = 16'($urandom_range(0, 8) - 4);
                        ry = 16'($urandom_range(0, 8) - 4);
                    end
                    5: begin
                        if ($urandom_range(0, 1))
                            rx = '0;
                        else
                            ry = '0;
                    end
                    6: begin
                        rx = corner_vals[$urandom_range(0, 4)];
                        ry = corner_vals[$urandom_range(0, 4)];
                    end
                    7: begin
                        // near the diagonals
                        ry = rx + 16'($urandom_range(0, 6) - 3);
                        if ($urandom_range(0, 1))
                            ry = -ry;
                    end
                    8, 9: begin
                        rx = rx >>> $urandom_range(0, 15);
                        ry = ry >>> $urandom_range(0, 15);
                    end
                    default: ;
                endcase
                push_sample(rx, ry);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("** compass_heading_classifier: PASSED **");
        else
            $display("** compass_heading_classifier: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/core/chc_pkg.sv
rtl/core/chc_cordic_stage.sv
rtl/core/compass_heading_classifier.sv
tb/tb_compass_heading_classifier.sv
